// File: src/uer_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ultrasonic echo ranger.
// No dependencies.
package uer_pkg;

    // Measurement sequencer, one-hot
    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_TRIG_LOW  = 5'b00010,
        PH_TRIG_HIGH = 5'b00100,
        PH_WAIT_RISE = 5'b01000,
        PH_MEASURE   = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_VALID    = 2'd1,
        ST_RANGE    = 2'd2,
        ST_DISABLED = 2'd3
    } t_status;

    // Register indexes on the configuration channel
    localparam logic [7:0] REG_MAX_RANGE = 8'd0;
    localparam logic [7:0] REG_ENABLE    = 8'd1;

    localparam int RANGE_W = 10;
    localparam int COUNT_W = 17;
    localparam int LIMIT_W = 16;  // largest timeout is 60177 us
    localparam int DIST_W  = 21;
    localparam int SCALED_W = 26; // max range * 58824 + 500 < 2^26

    // timeout = (max range * 58824 + 500) / 1000; the divide by 1000 is a
    // multiply by ceil(2^36 / 1000) and a shift by 36, exact below 2.6e8
    localparam logic [15:0]  TMO_SCALE = 16'd58824;
    localparam logic [9:0]   TMO_ROUND = 10'd500;
    localparam logic [26:0]  RECIP_1000 = 27'd68719477;
    localparam int           RECIP_SHIFT = 36;

    // Reset timeout pipeline values for a max range of 400 cm
    localparam logic [SCALED_W-1:0] SCALED_RST = 26'd23530100;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 16'd23530;

endpackage

// File: src/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// Top level of the ultrasonic echo ranger: trigger sequencer, echo timer and timeout.
// Depends on uer_pkg.
//
//  channel   dir   handshake                     payload
//  s_axis    in    s_axis_tvalid/s_axis_tready   tdata[7:0]: start_request, echo_level
//  m_axis    out   m_axis_tvalid/m_axis_tready   tdata[31:0]: trigger_level, busy_res,
//                                                done_res, status[1:0], distance_mcm[20:0]
//  cfg       in    i_cfg_valid/o_cfg_ready       i_cfg_index[7:0], i_cfg_data[9:0]
//
// One beat in and one beat out per cycle while m_axis_tready is high; each tick beat goes
// through an input register and a result register, which hold it while the output stalls.
// The sequencer update for one tick is combinational logic; the echo timer increment and
// the timeout compare set that path. A max range write reaches the timeout compare via
// the multiply registers r_scaled and r_limit, in time for the first tick beat after it.
// Reset (synchronous, active low) returns the sequencer to idle, the max range to 400 and
// disables the sensor. A stalled result holds in the output register while one more
// tick beat waits in the input register; s_axis_tready drops only when both are full.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int TRIG_LOW_TICKS  = 2,
    parameter int TRIG_HIGH_TICKS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] start_request, [1] echo_level, rest zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] trigger_level, [1] busy_res, [2] done_res,
                                        // [4:3] status, [25:5] distance_mcm, rest zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [RANGE_W-1:0] i_cfg_data
);

    localparam logic [COUNT_W-1:0] LOW_END  = COUNT_W'(TRIG_LOW_TICKS);
    localparam logic [COUNT_W-1:0] HIGH_END = COUNT_W'(TRIG_HIGH_TICKS);

    // ------------------------------------------------------------------
    // Configuration and timeout pipeline
    // ------------------------------------------------------------------
    logic                 r_enable;
    logic [SCALED_W-1:0]  r_scaled;
    logic [LIMIT_W-1:0]   r_limit;
    logic [SCALED_W+26:0] w_recip_prod;
    logic                 w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_recip_prod = (SCALED_W + 27)'(r_scaled) * (SCALED_W + 27)'(RECIP_1000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_scaled <= SCALED_RST;
            r_limit  <= LIMIT_RST;
        end else begin
            if (w_cfg_wr && i_cfg_index == REG_MAX_RANGE) begin
                r_scaled <= SCALED_W'(i_cfg_data) * SCALED_W'(TMO_SCALE)
                          + SCALED_W'(TMO_ROUND);
            end
            if (w_cfg_wr && i_cfg_index == REG_ENABLE) begin
                r_enable <= i_cfg_data[0];
            end
            r_limit <= w_recip_prod[RECIP_SHIFT +: LIMIT_W];
        end
    end

    // ------------------------------------------------------------------
    // Input register and output register handshake
    // ------------------------------------------------------------------
    logic       r_in_vld;
    logic [1:0] r_in_data;      // [0] start, [1] echo
    logic       r_out_vld;
    logic [31:0] r_out_data;
    logic       w_out_free;
    logic       w_advance;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_advance     = r_in_vld && w_out_free;
    assign s_axis_tready = !r_in_vld || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_phase               r_phase, n_phase;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_echo_prev;
    logic [DIST_W-1:0]    r_dist, n_dist;
    logic                 n_trig, n_done;
    t_status              n_status;
    t_phase               w_phase_cur;
    logic                 w_start, w_echo, w_rise;
    logic [COUNT_W-1:0]   w_count_inc;
    logic [DIST_W-1:0]    w_count_x17;

    assign w_start = r_in_data[0];
    assign w_echo  = r_in_data[1];
    assign w_rise  = w_echo && !r_echo_prev;
    assign w_count_x17 = (DIST_W'(r_count) << 4) + DIST_W'(r_count);

    always_comb begin
        // an undefined phase code behaves as idle
        case (r_phase)
            PH_IDLE, PH_TRIG_LOW, PH_TRIG_HIGH, PH_WAIT_RISE, PH_MEASURE: begin
                w_phase_cur = r_phase;
            end
            default: begin
                w_phase_cur = PH_IDLE;
            end
        endcase

        n_phase  = w_phase_cur;
        n_count  = r_count;
        n_dist   = r_dist;
        n_trig   = 1'b0;
        n_done   = 1'b0;
        n_status = ST_NONE;

        // start from idle: arm the trigger, or report disabled right away
        if (w_phase_cur == PH_IDLE && w_start) begin
            if (r_enable) begin
                n_phase = PH_TRIG_LOW;
                n_count = '0;
            end else begin
                n_done   = 1'b1;
                n_status = ST_DISABLED;
            end
        end

        w_count_inc = n_count + COUNT_W'(1);

        case (n_phase)
            PH_TRIG_LOW: begin
                n_count = w_count_inc;
                if (w_count_inc >= LOW_END) begin
                    n_phase = PH_TRIG_HIGH;
                    n_count = '0;
                end
            end
            PH_TRIG_HIGH: begin
                n_trig  = 1'b1;
                n_count = w_count_inc;
                if (w_count_inc >= HIGH_END) begin
                    n_phase = PH_WAIT_RISE;
                    n_count = '0;
                end
            end
            PH_WAIT_RISE: begin
                // the rising tick is the first high tick of the echo
                if (w_rise) begin
                    n_phase = PH_MEASURE;
                    n_count = COUNT_W'(1);
                end else begin
                    n_count = w_count_inc;
                end
                if (n_count > COUNT_W'(r_limit)) begin
                    n_phase  = PH_IDLE;
                    n_count  = '0;
                    n_done   = 1'b1;
                    n_status = ST_RANGE;
                    n_dist   = '0;
                end
            end
            PH_MEASURE: begin
                if (!w_echo) begin
                    n_dist   = w_count_x17;
                    n_phase  = PH_IDLE;
                    n_count  = '0;
                    n_done   = 1'b1;
                    n_status = ST_VALID;
                end else if (w_count_inc > COUNT_W'(r_limit)) begin
                    n_phase  = PH_IDLE;
                    n_count  = '0;
                    n_done   = 1'b1;
                    n_status = ST_RANGE;
                    n_dist   = '0;
                end else begin
                    n_count = w_count_inc;
                end
            end
            default: begin
                // idle: hold
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_echo_prev <= 1'b0;
            r_dist      <= '0;
        end else if (w_advance) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_echo_prev <= w_echo;
            r_dist      <= n_dist;
        end
    end

    // payload registers: load on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata[1:0];
        end
        if (w_advance) begin
            r_out_data <= {6'b0, n_dist, n_status, n_done,
                           (n_phase != PH_IDLE), n_trig};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[4:3] != ST_NONE)))
        else $error("status and done disagree");

    a_trig_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
        else $error("trigger high outside a measurement");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_out_free) |=> (r_in_vld && $stable(r_in_data)))
        else $error("pending tick beat lost while output stalled");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(r_phase) && $stable(r_count) && $stable(r_dist)))
        else $error("sequencer moved without a tick beat");

endmodule
